[design/cfe_pkg.sv]
// ----------------------------------------------------------------------------
// cfe_pkg: shared types for the COBS frame encoder
// Sequencer states and the control word that drives the run buffer chain.
// ----------------------------------------------------------------------------
package cfe_pkg;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CODE,
        ST_DATA
    } cfe_state_t;

    // Control word from the sequencer to the run buffer chain.
    typedef struct packed {
        logic wr;
        logic shift;
    } cfe_chain_ctrl_t;

endpackage

[design/cfe_cell.sv]
// ----------------------------------------------------------------------------
// cfe_cell: one byte cell of the run buffer chain
// Holds one buffered byte; loads a new byte when addressed, or takes its
// right neighbor's byte when the chain shifts toward the head.
// ----------------------------------------------------------------------------
module cfe_cell
    import cfe_pkg::*;
(
    input  logic       clk,
    input  logic       wr_sel,
    input  logic       shift,
    input  logic [7:0] wr_byte,
    input  logic [7:0] neighbor_byte,
    output logic [7:0] cell_byte
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Shift and write never happen in the same cycle.
    always_comb
    begin
        byte_next = byte_reg;
        if (shift)
        begin
            byte_next = neighbor_byte;
        end
        else if (wr_sel)
        begin
            byte_next = wr_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

[design/cfe_chain.sv]
// ----------------------------------------------------------------------------
// cfe_chain: run buffer as a row of byte cells
// A byte is written into the cell at the current run length; on a flush
// the row shifts toward the head (read out) one cell per cycle with shift set.
// ----------------------------------------------------------------------------
module cfe_chain
    import cfe_pkg::*;
#(
    parameter int MAX_PACKET = 32,
    parameter int IDX_W      = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1
)
(
    input  logic             clk,
    input  cfe_chain_ctrl_t  ctrl,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [7:0]       wr_byte,
    output logic [7:0]       head_byte
);

    logic [7:0] cell_bytes [MAX_PACKET];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PACKET; gi++)
        begin : g_cell
            logic [7:0] neighbor;

            // The last cell takes a filler byte; it is never read unwritten.
            if (gi == MAX_PACKET - 1)
            begin : g_tail
                assign neighbor = 8'h00;
            end
            else
            begin : g_body
                assign neighbor = cell_bytes[gi + 1];
            end

            cfe_cell u_cell (
                .clk           (clk),
                .wr_sel        (ctrl.wr && (wr_idx == IDX_W'(gi))),
                .shift         (ctrl.shift),
                .wr_byte       (wr_byte),
                .neighbor_byte (neighbor),
                .cell_byte     (cell_bytes[gi])
            );
        end
    endgenerate

    assign head_byte = cell_bytes[0];

endmodule

[design/cobs_frame_encoder_top.sv]
// ----------------------------------------------------------------------------
// cobs_frame_encoder_top: streaming COBS encoder
// Takes raw packet bytes and emits their COBS encoding, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one raw byte per item, with
// packet_end set on the last byte of a packet. The output channel
// (out_valid/out_ready) carries one encoded byte per item; frame_last marks
// the final byte of the packet and overflowed is set on it when bytes past
// MAX_PACKET were dropped. No leading delimiter is produced.
// A nonzero byte that does not end the packet is absorbed without a flush,
// so such bytes stream at one item per cycle. A zero byte within MAX_PACKET
// or a packet end starts a flush: a code byte, then the buffered bytes at one
// byte per cycle while the receiver takes them, as the run buffer row shifts
// toward its head; the input waits until the flush ends (two flushes for a
// zero last byte). The code state loads the first encoded byte for output.
// A stalled receiver holds the output register and pauses the flush; a
// new input item is taken while the last result still waits.
// Reset clears the sequencer, run length, byte count and overflow flag.
// ----------------------------------------------------------------------------
module cobs_frame_encoder_top
    import cfe_pkg::*;
#(
    parameter int MAX_PACKET = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       packet_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] coded_byte,
    output logic       frame_last,
    output logic       overflowed
);

    localparam int LEN_W = $clog2(MAX_PACKET + 1);
    localparam int IDX_W = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;

    cfe_state_t       state_reg,    state_next;
    logic [LEN_W-1:0] run_len_reg,  run_len_next;
    logic [LEN_W-1:0] count_reg,    count_next;
    logic [LEN_W-1:0] rem_reg,      rem_next;
    logic             ovf_reg,      ovf_next;
    logic             fl_end_reg,   fl_end_next;
    logic             end_pend_reg, end_pend_next;

    logic             out_valid_reg;
    logic [7:0]       coded_byte_reg;
    logic             frame_last_reg;
    logic             overflowed_reg;

    logic             slot_free;
    logic             emit;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic             emit_ovf;
    logic             finish;
    cfe_chain_ctrl_t  chain_ctrl;
    logic [7:0]       head_byte;

    // Run buffer row.
    cfe_chain #(
        .MAX_PACKET (MAX_PACKET),
        .IDX_W      (IDX_W)
    ) u_chain (
        .clk       (clk),
        .ctrl      (chain_ctrl),
        .wr_idx    (run_len_reg[IDX_W-1:0]),
        .wr_byte   (data_byte),
        .head_byte (head_byte)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    // Sequencer: next state and outputs.
    always_comb
    begin
        state_next    = state_reg;
        run_len_next  = run_len_reg;
        count_next    = count_reg;
        rem_next      = rem_reg;
        ovf_next      = ovf_reg;
        fl_end_next   = fl_end_reg;
        end_pend_next = end_pend_reg;
        emit          = 1'b0;
        emit_byte     = 8'h00;
        emit_last     = 1'b0;
        emit_ovf      = 1'b0;
        finish        = 1'b0;
        chain_ctrl    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (count_reg >= LEN_W'(MAX_PACKET))
                    begin
                        // Packet too long: drop the byte, an end still flushes.
                        ovf_next = 1'b1;
                        if (packet_end)
                        begin
                            fl_end_next   = 1'b1;
                            end_pend_next = 1'b0;
                            state_next    = ST_CODE;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + LEN_W'(1);
                        if (data_byte == 8'h00)
                        begin
                            // A zero closes the run; an end adds a lone code.
                            fl_end_next   = 1'b0;
                            end_pend_next = packet_end;
                            state_next    = ST_CODE;
                        end
                        else
                        begin
                            chain_ctrl.wr = 1'b1;
                            run_len_next  = run_len_reg + LEN_W'(1);
                            if (packet_end)
                            begin
                                fl_end_next   = 1'b1;
                                end_pend_next = 1'b0;
                                state_next    = ST_CODE;
                            end
                        end
                    end
                end
            end
            ST_CODE:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = 8'(run_len_reg) + 8'd1;
                    if (run_len_reg == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        rem_next   = run_len_reg;
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    emit             = 1'b1;
                    emit_byte        = head_byte;
                    chain_ctrl.shift = 1'b1;
                    rem_next         = rem_reg - LEN_W'(1);
                    if (rem_reg == LEN_W'(1))
                    begin
                        finish = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // End of a flush: mark the frame end or start the trailing flush.
        if (finish)
        begin
            emit_last    = fl_end_reg;
            emit_ovf     = fl_end_reg && ovf_reg;
            run_len_next = '0;
            if (fl_end_reg)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            else if (end_pend_reg)
            begin
                fl_end_next   = 1'b1;
                end_pend_next = 1'b0;
                state_next    = ST_CODE;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            run_len_reg  <= '0;
            count_reg    <= '0;
            rem_reg      <= '0;
            ovf_reg      <= 1'b0;
            fl_end_reg   <= 1'b0;
            end_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            run_len_reg  <= run_len_next;
            count_reg    <= count_next;
            rem_reg      <= rem_next;
            ovf_reg      <= ovf_next;
            fl_end_reg   <= fl_end_next;
            end_pend_reg <= end_pend_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            coded_byte_reg <= emit_byte;
            frame_last_reg <= emit_last;
            overflowed_reg <= emit_ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign coded_byte = coded_byte_reg;
    assign frame_last = frame_last_reg;
    assign overflowed = overflowed_reg;

endmodule

[design/cfe_checker.sv]
// ----------------------------------------------------------------------------
// cfe_checker: port-level checks for the COBS frame encoder
// Watches the top level's ports and flags encoding and handshake slips.
// ----------------------------------------------------------------------------
module cfe_checker
    import cfe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       packet_end,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] coded_byte,
    input logic       frame_last,
    input logic       overflowed
);

    // COBS output never carries a zero byte.
    a_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (coded_byte != 8'h00))
        else $error("encoded item is zero");

    // The overflow flag appears only on the final item of a frame.
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflowed) |-> frame_last)
        else $error("overflow flag on a non-final item");

    // A packet end always starts a flush, so the input pauses.
    a_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && packet_end) |=> !in_ready)
        else $error("input still ready after packet end");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(coded_byte)
            && $stable(frame_last)))
        else $error("stalled result changed");

endmodule

bind cobs_frame_encoder_top cfe_checker u_cfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .packet_end (packet_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .coded_byte (coded_byte),
    .frame_last (frame_last),
    .overflowed (overflowed)
);
